FILE: hdl/lbf_pkg.sv
// Shared types and constants for the LED burst flasher.
`timescale 1ns / 1ps
`default_nettype none

package lbf_pkg;

    // Mode codes carried by a set-mode beat
    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_ON    = 2'd1;
    localparam logic [1:0] MODE_CONT  = 2'd2;
    localparam logic [1:0] MODE_PAUSE = 2'd3;

    // Opcode of an input beat
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SET  = 1'b1;

    // Register map: index within the APB window (byte address 4*index)
    localparam int         APB_AW           = 4;
    localparam logic [1:0] REG_ON_TIME      = 2'd0;
    localparam logic [1:0] REG_OFF_TIME     = 2'd1;
    localparam logic [1:0] REG_FLASH_COUNT  = 2'd2;
    localparam logic [1:0] REG_CYCLE_PERIOD = 2'd3;

    // Register reset values
    localparam logic [15:0] RST_ON_TIME      = 16'd100;
    localparam logic [15:0] RST_OFF_TIME     = 16'd200;
    localparam logic [3:0]  RST_FLASH_COUNT  = 4'd2;
    localparam logic [23:0] RST_CYCLE_PERIOD = 24'd3000;

    typedef struct packed {
        logic [15:0] on_time;
        logic [15:0] off_time;
        logic [3:0]  flash_count;
        logic [23:0] cycle_period;
    } t_cfg;

    typedef struct packed {
        logic led;
        logic active;
    } t_res;

endpackage

`default_nettype wire

FILE: hdl/lbf_core.sv
// Flasher state and next-state logic: mode, elapsed time, pulse index, period, LED.
`timescale 1ns / 1ps
`default_nettype none

module lbf_core #(
    parameter int TIME_BITS = 24
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_step,
    input  wire logic          i_opcode,
    input  wire logic [1:0]    i_mode,
    input  wire lbf_pkg::t_cfg i_cfg,
    output lbf_pkg::t_res      o_res
);
    import lbf_pkg::*;

    localparam int CW = ((TIME_BITS > 24) ? TIME_BITS : 24) + 1;
    localparam logic [TIME_BITS-1:0] TIME_MAX   = {TIME_BITS{1'b1}};
    localparam logic [CW-1:0]        TIME_MAX_W = {{(CW-TIME_BITS){1'b0}}, TIME_MAX};
    localparam logic [TIME_BITS-1:0] PERIOD_RST = TIME_BITS'(3000);

    logic [1:0]           r_mode,    n_mode;
    logic [TIME_BITS-1:0] r_elapsed, n_elapsed;
    logic [4:0]           r_pulse,   n_pulse;
    logic [TIME_BITS-1:0] r_period,  n_period;
    logic                 r_led,     n_led;

    logic [16:0]          per;
    logic [21:0]          start;
    logic [22:0]          dark;
    logic [22:0]          dark_end;
    logic [21:0]          cont_prod;
    logic [CW-1:0]        t_w, start_w, dark_w, dark_end_w, period_w, cont_w, cyc_w;
    logic                 in_burst;
    logic                 flash;
    logic [TIME_BITS-1:0] t_inc;

    // Burst window of the pulse in progress
    always_comb begin
        per        = {1'b0, i_cfg.on_time} + {1'b0, i_cfg.off_time};
        start      = {17'b0, r_pulse} * {5'b0, per};
        dark       = {1'b0, start} + {7'b0, i_cfg.on_time};
        dark_end   = dark + {7'b0, i_cfg.off_time};
        cont_prod  = ({18'b0, i_cfg.flash_count} + 22'd1) * {5'b0, per};
        t_w        = {{(CW-TIME_BITS){1'b0}}, r_elapsed};
        period_w   = {{(CW-TIME_BITS){1'b0}}, r_period};
        start_w    = {{(CW-22){1'b0}}, start};
        dark_w     = {{(CW-23){1'b0}}, dark};
        dark_end_w = {{(CW-23){1'b0}}, dark_end};
        cont_w     = {{(CW-22){1'b0}}, cont_prod};
        cyc_w      = {{(CW-24){1'b0}}, i_cfg.cycle_period};
        in_burst   = r_pulse <= {1'b0, i_cfg.flash_count};
        flash      = (r_mode == MODE_CONT) || (r_mode == MODE_PAUSE);
        t_inc      = (r_elapsed == TIME_MAX) ? TIME_MAX : r_elapsed + TIME_BITS'(1);
    end

    // Next state for one beat
    always_comb begin
        n_mode    = r_mode;
        n_elapsed = r_elapsed;
        n_pulse   = r_pulse;
        n_period  = r_period;
        n_led     = r_led;
        if (i_opcode == OP_SET) begin
            n_mode = i_mode;
            unique case (i_mode)
                MODE_OFF: n_led = 1'b0;
                MODE_ON:  n_led = 1'b1;
                MODE_CONT: begin
                    if (r_mode != MODE_CONT) begin
                        n_period  = (cont_w > TIME_MAX_W) ? TIME_MAX
                                                          : cont_w[TIME_BITS-1:0];
                        n_elapsed = '0;
                        n_pulse   = '0;
                    end
                end
                MODE_PAUSE: begin
                    if (r_mode != MODE_PAUSE) begin
                        n_period  = (cyc_w > TIME_MAX_W) ? TIME_MAX
                                                         : cyc_w[TIME_BITS-1:0];
                        n_elapsed = '0;
                        n_pulse   = '0;
                    end
                end
                default: n_mode = r_mode;
            endcase
        end else if (flash) begin
            priority if (in_burst) begin
                // lit window, then dark window that advances the pulse
                if (t_w >= start_w && t_w < dark_w) begin
                    n_led = 1'b1;
                end else if (t_w >= dark_w && t_w < dark_end_w) begin
                    n_led   = 1'b0;
                    n_pulse = r_pulse + 5'd1;
                end
                n_elapsed = t_inc;
            end else if (t_w >= period_w) begin
                // restart the burst and evaluate time zero at once
                n_pulse = '0;
                if (i_cfg.on_time != '0) begin
                    n_led = 1'b1;
                end else if (i_cfg.off_time != '0) begin
                    n_led   = 1'b0;
                    n_pulse = 5'd1;
                end
                n_elapsed = TIME_BITS'(1);
            end else begin
                n_elapsed = t_inc;
            end
        end
    end

    // Hold state between beats
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_OFF;
            r_elapsed <= '0;
            r_pulse   <= '0;
            r_period  <= PERIOD_RST;
            r_led     <= 1'b0;
        end else if (i_step) begin
            r_mode    <= n_mode;
            r_elapsed <= n_elapsed;
            r_pulse   <= n_pulse;
            r_period  <= n_period;
            r_led     <= n_led;
        end
    end

    assign o_res.led    = n_led;
    assign o_res.active = (n_mode != MODE_OFF);

`ifndef SYNTHESIS
    // pulse index stops one past the largest flash count
    a_pulse_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pulse <= 5'd16)
        else $error("pulse index out of range");

    // off mode never leaves the LED lit
    a_off_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_OFF) |-> !r_led)
        else $error("LED lit in off mode");

    // a tick outside flash modes keeps the counters
    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_opcode == OP_TICK && !flash) |=> $stable(r_elapsed) && $stable(r_pulse))
        else $error("counters moved outside a flash mode");
`endif

endmodule

`default_nettype wire

FILE: hdl/led_burst_flasher.sv
// Top level of the LED burst flasher: handshake stages, APB registers, flasher core.
//
//   channel  dir  handshake                  payload
//   in       in   i_in_valid / o_in_ready    i_opcode, i_mode
//   out      out  o_out_valid / i_out_ready  o_led, o_active
//   apb      in   psel, penable, pwrite      paddr, pwdata, prdata, pready
//
// One beat per cycle sustained while the output is not stalled; a beat is held in the input
// register and its result is then registered in the output register.
// One pass of compare logic plus 5x17 multiplies for the pulse start and the burst period.
// Reset is synchronous and active low; the input and output data registers have no reset.
// A stalled output holds its beat while one more input beat waits in the input register.
`timescale 1ns / 1ps
`default_nettype none

module led_burst_flasher #(
    parameter int TIME_BITS = 24
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic                       i_opcode,
    input  wire logic [1:0]                 i_mode,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic                            o_led,
    output logic                            o_active,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [lbf_pkg::APB_AW-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import lbf_pkg::*;

    t_cfg       r_cfg;
    logic       r_in_valid;
    logic       r_in_opcode;
    logic [1:0] r_in_mode;
    logic       r_out_valid;
    logic       r_led;
    logic       r_active;
    logic       advance;
    logic       step;
    logic       cfg_wr;
    t_res       res;

    // Move a beat forward when the output register is free or being drained
    assign advance    = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && advance;
    assign o_in_ready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_opcode <= i_opcode;
            r_in_mode   <= i_mode;
        end
    end

    lbf_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_opcode (r_in_opcode),
        .i_mode   (r_in_mode),
        .i_cfg    (r_cfg),
        .o_res    (res)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_led    <= res.led;
            r_active <= res.active;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_led       = r_led;
    assign o_active    = r_active;

    // APB register writes
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.on_time      <= RST_ON_TIME;
            r_cfg.off_time     <= RST_OFF_TIME;
            r_cfg.flash_count  <= RST_FLASH_COUNT;
            r_cfg.cycle_period <= RST_CYCLE_PERIOD;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_ON_TIME:      r_cfg.on_time      <= pwdata[15:0];
                REG_OFF_TIME:     r_cfg.off_time     <= pwdata[15:0];
                REG_FLASH_COUNT:  r_cfg.flash_count  <= pwdata[3:0];
                REG_CYCLE_PERIOD: r_cfg.cycle_period <= pwdata[23:0];
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    // APB register reads
    always_comb begin
        unique case (paddr[3:2])
            REG_ON_TIME:      prdata = {16'b0, r_cfg.on_time};
            REG_OFF_TIME:     prdata = {16'b0, r_cfg.off_time};
            REG_FLASH_COUNT:  prdata = {28'b0, r_cfg.flash_count};
            REG_CYCLE_PERIOD: prdata = {8'b0, r_cfg.cycle_period};
            default:          prdata = '0;
        endcase
    end

`ifndef SYNTHESIS
    // a waiting beat is kept until it moves on
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> r_in_valid)
        else $error("input beat dropped");

    // an empty output register always lets a beat in
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    // an inactive result never shows a lit LED
    a_inactive_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_active) |-> !o_led)
        else $error("LED lit while inactive");
`endif

endmodule

`default_nettype wire
